@@ sv/dcst_pkg.sv @@
// Package for the dual-channel scope trace and peak-to-peak block.
// Holds field widths, arithmetic constants, register indexes and the stage-advance struct.
// No dependencies.
package dcst_pkg;

  // Field and internal widths
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int OFFSET_W   = 11;
  localparam int ROW_W      = 8;
  localparam int VPP_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = 33;  // centred sample times gain
  localparam int BASE_W     = 34;  // product plus mid-scale bias
  localparam int OFFT_W     = 40;  // offset term
  localparam int NUM_W      = 48;  // row numerator
  localparam int PD_W       = 28;  // span times full-scale millivolts
  localparam int P_W        = 12;  // millivolts before range scaling
  localparam int REM_W      = 17;  // remainder in the divide-by-65535 correction

  // Arithmetic constants
  localparam logic [GAIN_W-1:0]    GAIN_RESET = 16'd4096;
  localparam logic [SAMPLE_W-1:0]  FULL_SCALE = 16'hFFFF;
  localparam logic [ROW_W-1:0]     ROW_MIN    = 8'd40;
  localparam logic [ROW_W-1:0]     ROW_MAX    = 8'd219;
  localparam logic [PD_W-1:0]      MV_FULL    = 28'd3300;
  localparam logic [REM_W-1:0]     REM_LIMIT  = 17'd65535;

  localparam logic signed [BASE_W-1:0] MID_BIAS  = 34'sd134217728;  // 32768 * 4096
  localparam logic signed [NUM_W-1:0]  ROW_SCALE = 48'sd2864;       // 179 * 16
  localparam logic signed [OFFT_W-1:0] OFF_SCALE = 40'sd268431360;  // 65535 * 4096

  // Full-scale denominator 65535 * 65536 and the clamp thresholds
  localparam longint ROW_DEN = 64'd65535 * 64'd65536;
  localparam logic signed [NUM_W-1:0] ROW_HI_TH = NUM_W'(ROW_DEN * 64'd219);
  localparam logic signed [NUM_W-1:0] ROW_LO_TH = NUM_W'(ROW_DEN * 64'd41);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_A   = 3'd0,
    CFG_GAIN_B   = 3'd1,
    CFG_OFFSET_A = 3'd2,
    CFG_OFFSET_B = 3'd3,
    CFG_RANGE_A  = 3'd4,
    CFG_RANGE_B  = 3'd5
  } cfg_idx_e;

  // Load enables for the channel pipeline stages
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } adv_t;

endpackage

@@ sv/dcst_chan.sv @@
// One channel of the scope block: row scaling pipeline and min/max peak-to-peak tracking.
// Stages two to five; stage one (input register) lives in the top level.
// Depends on dcst_pkg.
module dcst_chan
  import dcst_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  adv_t                       adv_i,
  input  logic                       last_i,
  input  logic [SAMPLE_W-1:0]        sample_i,
  input  logic [GAIN_W-1:0]          gain_i,
  input  logic signed [OFFSET_W-1:0] offset_i,
  input  logic                       range_i,
  output logic [ROW_W-1:0]           row_o,
  output logic [VPP_W-1:0]           vpp_o
);

  // Stage two: centred product, offset term, folded min/max span
  logic signed [SAMPLE_W-1:0] ctr;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [OFFT_W-1:0]   offt_d, offt_q;
  logic [SAMPLE_W-1:0]        max_nxt, min_nxt;
  logic [SAMPLE_W-1:0]        max_q, min_q;
  logic [SAMPLE_W-1:0]        span_d, span_q;

  // Stage three: row numerator and millivolt product
  logic signed [BASE_W-1:0]   base;
  logic signed [NUM_W-1:0]    num_d, num_q;
  logic [PD_W-1:0]            pd_d, pd_q;

  // Stage four: clamped row and millivolts
  logic                       row_hi, row_lo;
  logic [ROW_W-1:0]           rk0;
  logic [REM_W-1:0]           rrem;
  logic [ROW_W-1:0]           row_d, row_q;
  logic [P_W-1:0]             pk0;
  logic [REM_W-1:0]           prem;
  logic [P_W-1:0]             p_d, p_q;

  // Stage five: range scaling
  logic [VPP_W-1:0]           vpp_d, vpp_q;
  logic [ROW_W-1:0]           row_out_q;

  // Centre the sample: flipping the top bit gives s - 32768 as a signed value
  always_comb begin
    ctr     = $signed({~sample_i[SAMPLE_W-1], sample_i[SAMPLE_W-2:0]});
    prod_d  = ctr * $signed({1'b0, gain_i});
    offt_d  = OFFT_W'(offset_i) * OFF_SCALE;
    max_nxt = (sample_i > max_q) ? sample_i : max_q;
    min_nxt = (sample_i < min_q) ? sample_i : min_q;
    span_d  = last_i ? (max_nxt - min_nxt) : '0;
  end

  // Hold the running min/max; restart them at the end of a frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
      min_q <= FULL_SCALE;
    end else if (adv_i.s2) begin
      max_q <= last_i ? '0 : max_nxt;
      min_q <= last_i ? FULL_SCALE : min_nxt;
    end
  end

  // Add the mid-scale bias, map onto 179 rows in sixteenths, add the offset
  always_comb begin
    base  = $signed({prod_q[PROD_W-1], prod_q}) + MID_BIAS;
    num_d = NUM_W'(base) * ROW_SCALE + NUM_W'(offt_q);
    pd_d  = PD_W'(span_q) * MV_FULL;
  end

  // Divide by 65535 * 65536: shift by 16, estimate by a second shift, correct once
  always_comb begin
    row_hi = (num_q >= ROW_HI_TH);
    row_lo = (num_q < ROW_LO_TH);
    rk0    = num_q[39:32];
    rrem   = {1'b0, num_q[31:16]} + REM_W'(rk0);
    if (row_hi) begin
      row_d = ROW_MAX;
    end else if (row_lo) begin
      row_d = ROW_MIN;
    end else begin
      row_d = rk0 + ROW_W'(rrem >= REM_LIMIT);
    end
    pk0 = pd_q[PD_W-1:16];
    prem = {1'b0, pd_q[15:0]} + REM_W'(pk0);
    p_d  = pk0 + P_W'(prem >= REM_LIMIT);
  end

  // Halve for the x2 range, times ten for the x10 range
  always_comb begin
    if (range_i) begin
      vpp_d = (VPP_W'(p_q) << 3) + (VPP_W'(p_q) << 1);
    end else begin
      vpp_d = VPP_W'(p_q >> 1);
    end
  end

  // Payload registers, loaded as each stage advances
  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      prod_q <= prod_d;
      offt_q <= offt_d;
      span_q <= span_d;
    end
    if (adv_i.s3) begin
      num_q <= num_d;
      pd_q  <= pd_d;
    end
    if (adv_i.s4) begin
      row_q <= row_d;
      p_q   <= p_d;
    end
    if (adv_i.s5) begin
      row_out_q <= row_q;
      vpp_q     <= vpp_d;
    end
  end

  assign row_o = row_out_q;
  assign vpp_o = vpp_q;

endmodule

@@ sv/dual_channel_scope_trace_and_vpp.sv @@
// Top level of the dual-channel scope trace and peak-to-peak block.
// Holds the configuration registers, input register and pipeline handshake.
// Depends on dcst_pkg and dcst_chan.
//
// Usage:
//   The slave stream carries one pair of ADC samples per transfer, channel A in
//   the low half of tdata and channel B in the high half; tlast marks the last
//   sample of an acquisition frame. The master stream returns one transfer per
//   input: both screen rows (clamped to 40..219), and on the frame's last sample
//   tlast set with both peak-to-peak values in millivolts (zero otherwise).
//   The pipeline has five register stages. Throughput is one pair per cycle
//   while the receiver keeps tready high; each stage holds one item and moves
//   on when the next stage is free or being emptied.
//   When the receiver stalls, the pipeline fills behind the output register and
//   tready falls only once all five stages hold an item; bubbles are squeezed out.
//   Reset empties the pipeline, restores gain 1.0, zero offset and the x2 range,
//   and restarts both min/max trackers.
//   Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user writes
//   them only while the block is idle, the block does not enforce it; unknown indexes are dropped.
module dual_channel_scope_trace_and_vpp
  import dcst_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,   // sample_a[15:0], sample_b[31:16]
  input  logic                  s_axis_tlast,   // frame_last
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [47:0]           m_axis_tdata,   // row_a[7:0], row_b[15:8],
                                                // vpp_a[31:16], vpp_b[47:32]
  output logic                  m_axis_tlast    // frame_done
);

  // Configuration registers
  logic [GAIN_W-1:0]          gain_a_q, gain_b_q;
  logic signed [OFFSET_W-1:0] offset_a_q, offset_b_q;
  logic                       range_a_q, range_b_q;

  // Pipeline control
  logic [5:1] vld_q, vld_d, ld;
  logic [6:1] rdy;
  adv_t       adv;

  // Input register and frame-end marks along the pipeline
  logic [SAMPLE_W-1:0] sample_a_q, sample_b_q;
  logic [5:1]          last_q;

  logic [ROW_W-1:0] row_a, row_b;
  logic [VPP_W-1:0] vpp_a, vpp_b;

  // Write a configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_a_q   <= GAIN_RESET;
      gain_b_q   <= GAIN_RESET;
      offset_a_q <= '0;
      offset_b_q <= '0;
      range_a_q  <= 1'b0;
      range_b_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_A:   gain_a_q   <= cfg_data_i;
        CFG_GAIN_B:   gain_b_q   <= cfg_data_i;
        CFG_OFFSET_A: offset_a_q <= $signed(cfg_data_i[OFFSET_W-1:0]);
        CFG_OFFSET_B: offset_b_q <= $signed(cfg_data_i[OFFSET_W-1:0]);
        CFG_RANGE_A:  range_a_q  <= cfg_data_i[0];
        CFG_RANGE_B:  range_b_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A stage is free when empty or when its item moves on this cycle
  always_comb begin
    rdy[6] = m_axis_tready;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    ld[1] = s_axis_tvalid && rdy[1];
    for (int k = 2; k <= 5; k++) begin
      ld[k] = vld_q[k-1] && rdy[k];
    end
    for (int k = 1; k <= 5; k++) begin
      vld_d[k] = ld[k] || (vld_q[k] && !rdy[k+1]);
    end
    adv.s2 = ld[2];
    adv.s3 = ld[3];
    adv.s4 = ld[4];
    adv.s5 = ld[5];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Capture the input transfer and carry the frame-end mark along
  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      sample_a_q <= s_axis_tdata[15:0];
      sample_b_q <= s_axis_tdata[31:16];
      last_q[1]  <= s_axis_tlast;
    end
    for (int k = 2; k <= 5; k++) begin
      if (ld[k]) begin
        last_q[k] <= last_q[k-1];
      end
    end
  end

  dcst_chan u_chan_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .last_i   (last_q[1]),
    .sample_i (sample_a_q),
    .gain_i   (gain_a_q),
    .offset_i (offset_a_q),
    .range_i  (range_a_q),
    .row_o    (row_a),
    .vpp_o    (vpp_a)
  );

  dcst_chan u_chan_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .last_i   (last_q[1]),
    .sample_i (sample_b_q),
    .gain_i   (gain_b_q),
    .offset_i (offset_b_q),
    .range_i  (range_b_q),
    .row_o    (row_b),
    .vpp_o    (vpp_b)
  );

  assign s_axis_tready = rdy[1];
  assign m_axis_tvalid = vld_q[5];
  assign m_axis_tlast  = last_q[5];
  assign m_axis_tdata  = {vpp_b, vpp_a, row_b, row_a};

`ifndef SYNTHESIS
  // Peak-to-peak fields stay zero away from the end of a frame
  a_vpp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[47:16] == '0))
    else $error("vpp nonzero on a transfer without frame_done");

  // Rows leave the block inside the screen window
  a_row_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (row_a >= ROW_MIN) && (row_a <= ROW_MAX) &&
                      (row_b >= ROW_MIN) && (row_b <= ROW_MAX))
    else $error("screen row outside 40..219");

  // An item handed to the output stage shows up as valid on the next cycle
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld[5] |=> m_axis_tvalid)
    else $error("output stage loaded but no valid result");
`endif

endmodule
